@@ hdl/psb_pkg.sv @@
// Package for the projected screen bounding box block: widths, codes,
// sequencer states and the rectangle helper functions.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package psb_pkg;

    localparam int FRAC_BITS = 16;
    // Column sums stay below 2^(64-F) in magnitude, so this width holds c + w too.
    localparam int C_W     = 66 - FRAC_BITS;
    localparam int MS_W    = C_W;
    localparam int NUM_W   = MS_W + 32;
    localparam int DIVN_W  = NUM_W + FRAC_BITS;
    localparam int CNT_W   = $clog2(DIVN_W + 1);
    localparam int SCR_W   = 32 + FRAC_BITS;
    localparam int CAP_W   = 34 + FRAC_BITS;
    localparam int V_W     = 36 + FRAC_BITS;
    localparam int MUL_W   = 33;
    localparam int N_TERMS = 3;
    localparam int CFG_IDX_W = 4;

    localparam logic [CAP_W-1:0] CAP = {1'b1, {(CAP_W - 1){1'b0}}};
    localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W - 1){1'b1}}};
    localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W - 1){1'b0}}};
    localparam logic [31:0] ONE_Q = 32'(1 << FRAC_BITS);
    localparam logic [SCR_W-1:0] FRAC_MASK = SCR_W'((1 << FRAC_BITS) - 1);
    localparam logic [SCR_W:0] HALF_Q = (SCR_W + 1)'(1 << (FRAC_BITS - 1));

    localparam logic [CFG_IDX_W-1:0] REG_COEF_X0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y0 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y1 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_W0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_W1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VP_ORG  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VP_SIZE = 4'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_CHK, S_PREP, S_MLO, S_ALO, S_MHI,
        S_AHI, S_DIV, S_WAIT, S_SCR, S_UPD, S_FIN
    } t_state;

    // Q32.F value to integer, truncated toward zero.
    function automatic logic signed [31:0] f_trunc(input logic signed [SCR_W-1:0] v);
        logic signed [SCR_W-1:0] b;
        if (v[SCR_W-1]) begin
            b = v + FRAC_MASK;
        end else begin
            b = v;
        end
        return 32'(b >>> FRAC_BITS);
    endfunction

    // (hi - lo + 1/2) truncated, saturated to 31 bits.
    function automatic logic [30:0] f_extent(input logic signed [SCR_W-1:0] lo,
                                             input logic signed [SCR_W-1:0] hi);
        logic [SCR_W:0] d;
        logic [SCR_W:0] t;
        d = (SCR_W + 1)'(hi) - (SCR_W + 1)'(lo);
        t = (d + HALF_Q) >> FRAC_BITS;
        if (|t[SCR_W:31]) begin
            return 31'h7FFF_FFFF;
        end
        return t[30:0];
    endfunction

endpackage

@@ hdl/psb_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on psb_pkg for the operand width.
`timescale 1ns / 1ps

module psb_mul import psb_pkg::*; (
    input  logic                        i_clk,
    input  logic signed [MUL_W-1:0]     i_a,
    input  logic signed [MUL_W-1:0]     i_b,
    output logic signed [2*MUL_W-1:0]   o_prod
);

    logic signed [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ hdl/psb_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on psb_pkg for the numerator and divisor widths.
`timescale 1ns / 1ps

module psb_div import psb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIVN_W-1:0]   i_num,
    input  logic [MS_W-1:0]     i_den,
    output logic                o_busy,
    output logic [DIVN_W-1:0]   o_quo
);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [MS_W-1:0]   r_rem;
    logic [MS_W-1:0]   r_den;
    logic [DIVN_W-1:0] r_quo;
    logic [MS_W:0]     rem_sh;
    logic [MS_W:0]     rem_sub;
    logic              ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVN_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVN_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[MS_W-1:0] : rem_sh[MS_W-1:0];
            r_quo <= {r_quo[DIVN_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

@@ hdl/projected_screen_bbox_unit.sv @@
// Projected screen bounding box: top level with sequencer, registers and box state.
// Depends on psb_pkg, psb_mul and psb_div.
//
// Usage: vertices (signed Q16.16 x, y, z and a last flag) enter on the input
// valid/ready channel, one at a time. Each vertex runs through the x, y and w
// columns of the transform on one shared multiplier, then for each screen
// axis two more products and a bit-serial division; a vertex with w of zero
// skips both divisions. Input ready is high only while the sequencer is idle.
// A vertex with the last flag set loads one rectangle item into the output
// register for the output channel when its work ends and clears the box state.
// The result sits in an output register: the next vertex is taken while it
// waits. Only when a further group ends before the receiver has taken the
// previous rectangle does the sequencer hold until it can load the register.
// The configuration channel is always ready; writes are registered.
// Reset (synchronous, active low) restores the default transform, clears the
// box and the error flag and drops output valid.
`timescale 1ns / 1ps

module projected_screen_bbox_unit import psb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [31:0]      i_pos_x,
    input  logic signed [31:0]      i_pos_y,
    input  logic signed [31:0]      i_pos_z,
    input  logic                    i_last_vertex,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [31:0]      o_rect_x,
    output logic signed [31:0]      o_rect_y,
    output logic [30:0]             o_rect_w,
    output logic [30:0]             o_rect_h,
    output logic                    o_div_zero_seen,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]             i_cfg_data
);

    t_state r_state, n_state;

    logic [63:0] r_coef [6];
    logic [63:0] r_vp_origin;
    logic [63:0] r_vp_size;

    logic [1:0] r_col;
    logic [1:0] r_term;
    logic       r_axis;
    logic       r_last;
    logic signed [31:0] r_x, r_y, r_z;

    logic signed [C_W-1:0]   r_acc [3];
    logic [MS_W-1:0]         r_ms;
    logic [MS_W-1:0]         r_d;
    logic                    r_neg;
    logic [NUM_W-1:0]        r_num;
    logic signed [V_W-1:0]   r_sq;
    logic signed [SCR_W-1:0] r_min [2];
    logic signed [SCR_W-1:0] r_max [2];
    logic                    r_err;

    logic               r_out_valid;
    logic signed [31:0] r_rect_x, r_rect_y;
    logic [30:0]        r_rect_w, r_rect_h;
    logic               r_rect_err;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic                      div_start, div_busy;
    logic [DIVN_W-1:0]         div_quo;

    logic [63:0]             coef_word;
    logic [31:0]             coef_half;
    logic signed [31:0]      pos_sel;
    logic [31:0]             size_sel;
    logic signed [31:0]      org_sel;
    logic signed [C_W-1:0]   c_sel, w_val;
    logic signed [C_W:0]     s_sum;
    logic [C_W:0]            s_abs, w_abs;
    logic [CAP_W-1:0]        q_cap;
    logic signed [V_W-1:0]   v_sum;
    logic signed [SCR_W-1:0] v_sat;
    logic signed [C_W-1:0]   term_q;
    logic                    in_acc, out_load, empty;

    psb_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    psb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_num, FRAC_BITS'(0)}),
        .i_den   (r_d),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Operand and datapath selection.
    always_comb begin
        coef_word = r_coef[{r_col, r_term[1]}];
        coef_half = (r_term == 2'd1) ? coef_word[31:0] : coef_word[63:32];
        case (r_term)
            2'd0:    pos_sel = r_x;
            2'd1:    pos_sel = r_y;
            default: pos_sel = r_z;
        endcase
        size_sel = r_axis ? r_vp_size[31:0] : r_vp_size[63:32];
        org_sel  = r_axis ? r_vp_origin[31:0] : r_vp_origin[63:32];
        c_sel    = r_axis ? r_acc[1] : r_acc[0];
        w_val    = r_acc[2];
        s_sum    = (C_W + 1)'(c_sel) + (C_W + 1)'(w_val);
        s_abs    = s_sum[C_W] ? -s_sum : s_sum;
        w_abs    = w_val[C_W-1] ? -((C_W + 1)'(w_val)) : (C_W + 1)'(w_val);
        term_q   = C_W'(prod >>> FRAC_BITS);
        q_cap    = (div_quo > DIVN_W'(CAP)) ? CAP : div_quo[CAP_W-1:0];
        v_sum    = r_sq + (V_W'(org_sel) <<< FRAC_BITS);
        if (v_sum > V_W'(SCR_MAX)) begin
            v_sat = SCR_MAX;
        end else if (v_sum < V_W'(SCR_MIN)) begin
            v_sat = SCR_MIN;
        end else begin
            v_sat = v_sum[SCR_W-1:0];
        end
        empty = r_min[0] > r_max[0];
    end

    // Next state and unit controls.
    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                mul_a   = {coef_half[31], coef_half};
                mul_b   = {pos_sel[31], pos_sel};
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_col == 2'(N_TERMS - 1) && r_term == 2'(N_TERMS - 1)) begin
                    n_state = S_CHK;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_CHK: begin
                n_state = (w_val == '0) ? S_FIN : S_PREP;
            end
            S_PREP: begin
                n_state = S_MLO;
            end
            S_MLO: begin
                mul_a   = {1'b0, r_ms[31:0]};
                mul_b   = {1'b0, size_sel};
                n_state = S_ALO;
            end
            S_ALO: begin
                n_state = S_MHI;
            end
            S_MHI: begin
                mul_a   = MUL_W'(r_ms[MS_W-1:32]);
                mul_b   = {1'b0, size_sel};
                n_state = S_AHI;
            end
            S_AHI: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                div_start = 1'b1;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (!div_busy) begin
                    n_state = S_SCR;
                end
            end
            S_SCR: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = r_axis ? S_FIN : S_PREP;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0]   <= {ONE_Q, 32'd0};
            r_coef[1]   <= '0;
            r_coef[2]   <= {32'd0, ONE_Q};
            r_coef[3]   <= '0;
            r_coef[4]   <= '0;
            r_coef[5]   <= {32'd0, ONE_Q};
            r_vp_origin <= '0;
            r_vp_size   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COEF_X0: r_coef[0]   <= i_cfg_data;
                REG_COEF_X1: r_coef[1]   <= i_cfg_data;
                REG_COEF_Y0: r_coef[2]   <= i_cfg_data;
                REG_COEF_Y1: r_coef[3]   <= i_cfg_data;
                REG_COEF_W0: r_coef[4]   <= i_cfg_data;
                REG_COEF_W1: r_coef[5]   <= i_cfg_data;
                REG_VP_ORG:  r_vp_origin <= i_cfg_data;
                REG_VP_SIZE: r_vp_size   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer counters, box state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_term      <= '0;
            r_axis      <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_min[0]    <= SCR_MAX;
            r_min[1]    <= SCR_MAX;
            r_max[0]    <= SCR_MIN;
            r_max[1]    <= SCR_MIN;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_col  <= '0;
                    r_term <= '0;
                    r_axis <= 1'b0;
                end
                S_ACC: begin
                    if (r_term == 2'(N_TERMS - 1)) begin
                        r_term <= '0;
                        r_col  <= r_col + 1'b1;
                    end else begin
                        r_term <= r_term + 1'b1;
                    end
                end
                S_CHK: begin
                    if (w_val == '0) begin
                        r_err <= 1'b1;
                    end
                end
                S_UPD: begin
                    r_axis <= 1'b1;
                    if (v_sat < r_min[r_axis]) begin
                        r_min[r_axis] <= v_sat;
                    end
                    if (v_sat > r_max[r_axis]) begin
                        r_max[r_axis] <= v_sat;
                    end
                end
                default: ;
            endcase
            if (out_load) begin
                r_err       <= 1'b0;
                r_min[0]    <= SCR_MAX;
                r_min[1]    <= SCR_MAX;
                r_max[0]    <= SCR_MIN;
                r_max[1]    <= SCR_MIN;
            end
        end
    end

    // Vertex payload and arithmetic datapath.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x      <= i_pos_x;
            r_y      <= i_pos_y;
            r_z      <= i_pos_z;
            r_last   <= i_last_vertex;
            r_acc[0] <= C_W'($signed(r_coef[1][31:0]));
            r_acc[1] <= C_W'($signed(r_coef[3][31:0]));
            r_acc[2] <= C_W'($signed(r_coef[5][31:0]));
        end
        case (r_state)
            S_ACC: r_acc[r_col] <= r_acc[r_col] + term_q;
            S_PREP: begin
                r_ms  <= s_abs[MS_W-1:0];
                r_d   <= MS_W'(w_abs << 1);
                r_neg <= s_sum[C_W] ^ w_val[C_W-1];
            end
            S_ALO: r_num <= NUM_W'(prod[63:0]);
            S_AHI: r_num <= r_num + (NUM_W'(prod[63:0]) << 32);
            S_SCR: r_sq  <= r_neg ? -(V_W'(q_cap)) : V_W'(q_cap);
            default: ;
        endcase
        if (out_load) begin
            r_rect_err <= r_err;
            if (empty) begin
                r_rect_x <= '0;
                r_rect_y <= '0;
                r_rect_w <= '0;
                r_rect_h <= '0;
            end else begin
                r_rect_x <= f_trunc(r_min[0]);
                r_rect_y <= f_trunc(r_min[1]);
                r_rect_w <= f_extent(r_min[0], r_max[0]);
                r_rect_h <= f_extent(r_min[1], r_max[1]);
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rect_x        = r_rect_x;
    assign o_rect_y        = r_rect_y;
    assign o_rect_w        = r_rect_w;
    assign o_rect_h        = r_rect_h;
    assign o_div_zero_seen = r_rect_err;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready stayed high after an item was taken");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN && r_last))
        else $error("result raised outside the end of a group");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCR) |-> !div_busy)
        else $error("quotient used while the divider is still running");

endmodule

@@ verif/psb_checker.sv @@
// Checker for the projected screen bounding box block: watches the vertex,
// rectangle and register channels, predicts each rectangle and compares.
// Depends on psb_pkg for widths and register indexes.
`timescale 1ns / 1ps

module psb_checker import psb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic signed [31:0]   i_pos_z,
    input  logic                 i_last_vertex,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic signed [31:0]   i_rect_x,
    input  logic signed [31:0]   i_rect_y,
    input  logic [30:0]          i_rect_w,
    input  logic [30:0]          i_rect_h,
    input  logic                 i_div_zero_seen,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [30:0] w;
        logic [30:0] h;
        logic        dz;
    } t_rect;

    localparam longint BOX_MAX = (64'sd1 <<< (31 + FRAC_BITS)) - 1;
    localparam longint BOX_MIN = -(64'sd1 <<< (31 + FRAC_BITS));

    t_rect       rect_q[$];
    logic [63:0] coef_x0, coef_x1, coef_y0, coef_y1, coef_w0, coef_w1;
    logic [63:0] vp_org, vp_size;
    longint      box_min_x, box_max_x, box_min_y, box_max_y;
    logic        zero_w_seen;
    int          mismatches;

    function automatic longint column_sum(input logic [63:0] p0, input logic [63:0] p1,
                                          input logic signed [31:0] x,
                                          input logic signed [31:0] y,
                                          input logic signed [31:0] z);
        longint a, b, c;
        a = longint'($signed(p0[63:32])) * longint'(x);
        b = longint'($signed(p0[31:0])) * longint'(y);
        c = longint'($signed(p1[63:32])) * longint'(z);
        return (a >>> FRAC_BITS) + (b >>> FRAC_BITS) + (c >>> FRAC_BITS)
               + longint'($signed(p1[31:0]));
    endfunction

    // Exact (c + w) * size / (2w) in Q.F, magnitude capped, then origin added
    // and the sum saturated to the Q32.F range.
    function automatic longint screen_coord(input longint c, input longint w,
                                            input logic [31:0] size,
                                            input logic signed [31:0] org);
        longint       s, v;
        logic         neg;
        logic [63:0]  ms, mw;
        logic [127:0] num, q;
        s   = c + w;
        neg = (s < 0) != (w < 0);
        ms  = (s < 0) ? 64'(-s) : 64'(s);
        mw  = (w < 0) ? 64'(-w) : 64'(w);
        num = ({64'd0, ms} * {96'd0, size}) << FRAC_BITS;
        q   = num / ({64'd0, mw} << 1);
        if (q > (128'd1 << (33 + FRAC_BITS))) begin
            q = 128'd1 << (33 + FRAC_BITS);
        end
        v = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        v = v + longint'(org) * (64'sd1 <<< FRAC_BITS);
        if (v > BOX_MAX) v = BOX_MAX;
        if (v < BOX_MIN) v = BOX_MIN;
        return v;
    endfunction

    function automatic logic [30:0] span_px(input longint lo, input longint hi);
        logic [63:0] sp;
        sp = (64'(hi - lo) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (sp > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sp[30:0];
    endfunction

    function automatic logic [31:0] to_pixel(input longint v);
        longint r;
        r = (v < 0) ? -((-v) >>> FRAC_BITS) : (v >>> FRAC_BITS);
        return r[31:0];
    endfunction

    task automatic clear_box();
        box_min_x   = BOX_MAX;
        box_max_x   = BOX_MIN;
        box_min_y   = BOX_MAX;
        box_max_y   = BOX_MIN;
        zero_w_seen = 1'b0;
    endtask

    task automatic take_vertex();
        longint cx, cy, cw, sx, sy;
        t_rect  r;
        cx = column_sum(coef_x0, coef_x1, i_pos_x, i_pos_y, i_pos_z);
        cy = column_sum(coef_y0, coef_y1, i_pos_x, i_pos_y, i_pos_z);
        cw = column_sum(coef_w0, coef_w1, i_pos_x, i_pos_y, i_pos_z);
        if (cw == 0) begin
            zero_w_seen = 1'b1;
        end else begin
            sx = screen_coord(cx, cw, vp_size[63:32], vp_org[63:32]);
            sy = screen_coord(cy, cw, vp_size[31:0], vp_org[31:0]);
            if (sx < box_min_x) box_min_x = sx;
            if (sx > box_max_x) box_max_x = sx;
            if (sy < box_min_y) box_min_y = sy;
            if (sy > box_max_y) box_max_y = sy;
        end
        if (i_last_vertex) begin
            if (box_min_x > box_max_x) begin
                r = '0;
            end else begin
                r.x = to_pixel(box_min_x);
                r.y = to_pixel(box_min_y);
                r.w = span_px(box_min_x, box_max_x);
                r.h = span_px(box_min_y, box_max_y);
            end
            r.dz = zero_w_seen;
            rect_q.push_back(r);
            clear_box();
        end
    endtask

    task automatic note_failure(input t_rect want, input t_rect got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t rect mismatch: expected x=%0d y=%0d w=%0d h=%0d dz=%0b",
                     $realtime, $signed(want.x), $signed(want.y), want.w, want.h, want.dz);
            $display("%0t                actual   x=%0d y=%0d w=%0d h=%0d dz=%0b",
                     $realtime, $signed(got.x), $signed(got.y), got.w, got.h, got.dz);
        end
    endtask

    always @(posedge i_clk) begin
        t_rect got, want;
        if (!i_rst_n) begin
            coef_x0 = 64'h0001_0000_0000_0000;
            coef_x1 = '0;
            coef_y0 = 64'h0000_0000_0001_0000;
            coef_y1 = '0;
            coef_w0 = '0;
            coef_w1 = 64'h0000_0000_0001_0000;
            vp_org  = '0;
            vp_size = '0;
            clear_box();
            rect_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_rect_x, i_rect_y, i_rect_w, i_rect_h, i_div_zero_seen};
                if (rect_q.size() == 0) begin
                    want = '0;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t rectangle with none expected: x=%0d y=%0d",
                                 $realtime, i_rect_x, i_rect_y);
                    end
                end else begin
                    want = rect_q.pop_front();
                    if (got != want) note_failure(want, got);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_COEF_X0: coef_x0 = i_cfg_data;
                    REG_COEF_X1: coef_x1 = i_cfg_data;
                    REG_COEF_Y0: coef_y0 = i_cfg_data;
                    REG_COEF_Y1: coef_y1 = i_cfg_data;
                    REG_COEF_W0: coef_w0 = i_cfg_data;
                    REG_COEF_W1: coef_w1 = i_cfg_data;
                    REG_VP_ORG:  vp_org  = i_cfg_data;
                    REG_VP_SIZE: vp_size = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) take_vertex();
        end
        o_pending <= rect_q.size();
        o_errors  <= mismatches;
    end

    initial begin
        mismatches = 0;
    end

endmodule

@@ verif/testbench.sv @@
// Top of the bounding box testbench: clock, reset, vertex and register
// stimulus, rectangle back-pressure and the verdict.
// Depends on psb_pkg, projected_screen_bbox_unit and psb_checker.
`timescale 1ns / 1ps

module testbench import psb_pkg::*; ();

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [31:0]   i_pos_x = '0;
    logic signed [31:0]   i_pos_y = '0;
    logic signed [31:0]   i_pos_z = '0;
    logic                 i_last_vertex = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [31:0]   o_rect_x, o_rect_y;
    logic [30:0]          o_rect_w, o_rect_h;
    logic                 o_div_zero_seen;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;
    int                   rects_pending, fail_count;
    bit                   hold_req = 0;
    bit                   tx_calm = 0;
    bit                   rx_calm = 0;

    projected_screen_bbox_unit u_dut (.*);

    psb_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready),
        .i_pos_x, .i_pos_y, .i_pos_z, .i_last_vertex,
        .i_out_valid(o_out_valid), .i_out_ready, .i_rect_x(o_rect_x), .i_rect_y(o_rect_y),
        .i_rect_w(o_rect_w), .i_rect_h(o_rect_h), .i_div_zero_seen(o_div_zero_seen),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_pending(rects_pending), .o_errors(fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Rectangle receiver: random stalls, plus one long hold-off on request.
    initial begin
        int  stall;
        int  r;
        bit  hold_done;
        stall = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                stall = 3000;
                hold_done = 1;
            end
            if (stall > 0) begin
                stall--;
            end else if (!rx_calm) begin
                r = $urandom_range(0, 99);
                if (r < 10) stall = $urandom_range(1, 4);
                else if (r < 12) stall = $urandom_range(20, 80);
            end
            i_out_ready <= (stall == 0);
        end
    end

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic last);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        gap = (tx_calm || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                 : $urandom_range(20, 80);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_pos_z       <= z;
        i_last_vertex <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Registers change only with no rectangle owed and the sequencer drained.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rects_pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] mild_coef();
        return 32'(int'($urandom_range(0, 262144)) - 131072);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] coord(input bit wide);
        return wide ? $urandom : 32'(int'($urandom_range(0, 524288)) - 262144);
    endfunction

    // Settings: 0 mild transform, 1 fully random, 2 largest viewport,
    // 3 w column zero, 4 w from z only with origin at the opposite corner.
    task automatic load_setting(input int kind);
        logic [63:0] w0, w1, org, sz;
        wait_idle();
        w0  = {mild_coef() >>> 3, mild_coef() >>> 3};
        w1  = {mild_coef() >>> 3, 32'h0001_0000};
        org = {32'(int'($urandom_range(0, 2000)) - 1000), 32'(int'($urandom_range(0, 2000)) - 1000)};
        sz  = {32'($urandom_range(0, 4096)), 32'($urandom_range(0, 4096))};
        case (kind)
            1: begin w0 = rand64(); w1 = rand64(); org = rand64(); sz = rand64(); end
            2: begin org = 64'h7FFF_FFFF_8000_0000; sz = '1; end
            3: begin w0 = '0; w1 = '0; end
            4: begin
                w0 = '0;
                w1 = 64'h0001_0000_0000_0000;
                org = 64'h8000_0000_7FFF_FFFF;
                sz = {32'd0, $urandom};
            end
            default: ;
        endcase
        write_reg(REG_COEF_X0, kind == 1 ? rand64() : {mild_coef(), mild_coef()});
        write_reg(REG_COEF_X1, kind == 1 ? rand64() : {mild_coef(), mild_coef()});
        write_reg(REG_COEF_Y0, kind == 1 ? rand64() : {mild_coef(), mild_coef()});
        write_reg(REG_COEF_Y1, kind == 1 ? rand64() : {mild_coef(), mild_coef()});
        write_reg(REG_COEF_W0, w0);
        write_reg(REG_COEF_W1, w1);
        write_reg(REG_VP_ORG, org);
        write_reg(REG_VP_SIZE, sz);
        // Indexes past the register file must be ignored.
        write_reg(CFG_IDX_W'($urandom_range(8, 15)), rand64());
    endtask

    task automatic random_groups(input int count, input int kind);
        int  n, len;
        bit  wide;
        n = 0;
        while (n < count) begin
            len = $urandom_range(1, 6);
            wide = (kind == 1) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
                if (kind == 4 && $urandom_range(0, 4) == 0) begin
                    send_vertex(coord(wide), coord(wide), '0, k == len - 1);
                end else begin
                    send_vertex(coord(wide), coord(wide), coord(wide), k == len - 1);
                end
                n++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity x and y, w taken from z, so z of zero gives w of zero.
        wait_idle();
        write_reg(REG_COEF_X0, 64'h0001_0000_0000_0000);
        write_reg(REG_COEF_X1, 64'h0);
        write_reg(REG_COEF_Y0, 64'h0000_0000_0001_0000);
        write_reg(REG_COEF_Y1, 64'h0);
        write_reg(REG_COEF_W0, 64'h0);
        write_reg(REG_COEF_W1, 64'h0001_0000_0000_0000);
        write_reg(REG_VP_ORG, {32'd100, -32'sd50});
        write_reg(REG_VP_SIZE, {32'd640, 32'd480});
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
        send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000, 1'b1);
        send_vertex(32'h0000_4000, 32'h0000_C000, 32'hFFFF_0000, 1'b1);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        send_vertex(32'h1234_5678, 32'hEDCB_A987, 32'h0, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h0, 1'b1);

        for (int p = 0; p < 7; p++) begin
            int kind;
            kind = (p < 5) ? p : $urandom_range(0, 4);
            tx_calm = (p % 3 == 2);
            rx_calm = (p % 3 == 0);
            load_setting(kind);
            if (p == 1) begin
                // Receiver holds off while single-vertex groups pile up.
                hold_req = 1;
                tx_calm = 1;
                for (int k = 0; k < 8; k++) begin
                    send_vertex(coord(0), coord(0), coord(0), 1'b1);
                end
                tx_calm = 0;
            end
            random_groups(125, kind);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rects_pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

@@ projected_screen_bbox_unit.f @@
hdl/psb_pkg.sv
hdl/psb_mul.sv
hdl/psb_div.sv
hdl/projected_screen_bbox_unit.sv
verif/psb_checker.sv
verif/testbench.sv
